// ----- src/pulse_current_waveform_sequencer_top_defines.svh -----
// Assertion helpers for the pulse current waveform sequencer.
`ifndef PULSE_CURRENT_WAVEFORM_SEQUENCER_TOP_DEFINES_SVH
`define PULSE_CURRENT_WAVEFORM_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PCWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcws: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define PCWS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcws: next-cycle check failed");
`else
`define PCWS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PCWS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- src/pcws_pkg.sv -----
package pcws_pkg;

  localparam int LEVEL_W = 12;
  localparam int INC_W   = 8;
  localparam int TICK_W  = 16;
  localparam int WORD_W  = 15;
  localparam int CODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam int unsigned PCWS_START_TICKS = 1;
  localparam int unsigned PCWS_STEP_TICKS  = 50;

  localparam logic [WORD_W-1:0]  DAC_CMD   = 15'h7000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'hFFF;

  localparam logic [TICK_W-1:0] RISE_TICKS_RST = 16'd30;
  localparam logic [TICK_W-1:0] PEAK_TICKS_RST = 16'd120;
  localparam logic [TICK_W-1:0] BASE_TICKS_RST = 16'd400;

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_LEVEL     = 3'd0,
    REG_START_LEVEL    = 3'd1,
    REG_PEAK_LEVEL     = 3'd2,
    REG_STEP_LEVEL     = 3'd3,
    REG_RISE_INCREMENT = 3'd4,
    REG_RISE_TICKS     = 3'd5,
    REG_PEAK_TICKS     = 3'd6,
    REG_BASE_TICKS     = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_RISE  = 5'b00001,
    PH_START = 5'b00010,
    PH_PEAK  = 5'b00100,
    PH_STEP  = 5'b01000,
    PH_BASE  = 5'b10000
  } phase_t;

  localparam logic [CODE_W-1:0] CODE_RISE  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_START = 3'd1;
  localparam logic [CODE_W-1:0] CODE_PEAK  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_STEP  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BASE  = 3'd4;

  function automatic logic [CODE_W-1:0] phase_code(phase_t ph);
    logic [CODE_W-1:0] code;
    unique case (ph)
      PH_RISE:  code = CODE_RISE;
      PH_START: code = CODE_START;
      PH_PEAK:  code = CODE_PEAK;
      PH_STEP:  code = CODE_STEP;
      PH_BASE:  code = CODE_BASE;
      default:  code = CODE_RISE;
    endcase
    return code;
  endfunction

endpackage

// ----- src/pcws_cfg_if.sv -----
interface pcws_cfg_if import pcws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/pcws_in_if.sv -----
interface pcws_in_if import pcws_pkg::*; ();
  logic valid;
  logic ready;
  logic enable;
  logic dac_ready;

  modport source (output valid, enable, dac_ready, input ready);
  modport sink   (input valid, enable, dac_ready, output ready);
endinterface

// ----- src/pcws_out_if.sv -----
interface pcws_out_if import pcws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] dac_word;
  logic [CODE_W-1:0] phase;

  modport source (output valid, dac_word, phase, input ready);
  modport sink   (input valid, dac_word, phase, output ready);
endinterface

// ----- src/pulse_current_waveform_sequencer_top.sv -----
// A DAC word is registered on its tick transfer and shows on the output in the cycle after it.
// Throughput: one tick per clock; input stalls only while a word waits unread.
// The phase, counter and ramp level are computed in one pass through one 8x16
// multiplier, one add and saturate, all from the phase, counter and config registers.
// Reset (rst, synchronous): rise phase, counter zero, output empty,
// configuration back to its default values.
`include "pulse_current_waveform_sequencer_top_defines.svh"

module pulse_current_waveform_sequencer_top import pcws_pkg::*; #(
  parameter int unsigned START_TICKS = PCWS_START_TICKS,
  parameter int unsigned STEP_TICKS  = PCWS_STEP_TICKS
) (
  input logic         clk,
  input logic         rst,
  pcws_cfg_if.sink    cfg,
  pcws_in_if.sink     tick,
  pcws_out_if.source  dac
);

  // Hold limits at counter width.
  localparam logic [TICK_W-1:0] START_LIM = TICK_W'(START_TICKS);
  localparam logic [TICK_W-1:0] STEP_LIM  = TICK_W'(STEP_TICKS);

  // Configuration registers.
  logic [LEVEL_W-1:0] base_level;
  logic [LEVEL_W-1:0] start_level;
  logic [LEVEL_W-1:0] peak_level;
  logic [LEVEL_W-1:0] step_level;
  logic [INC_W-1:0]   rise_increment;
  logic [TICK_W-1:0]  rise_ticks;
  logic [TICK_W-1:0]  peak_ticks;
  logic [TICK_W-1:0]  base_ticks;

  // Waveform state.
  phase_t             phase_q;
  phase_t             phase_next;
  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  tick_count_next;
  logic [LEVEL_W-1:0] level_next;

  // Output register.
  logic               out_valid;
  logic [WORD_W-1:0]  out_word;
  logic [CODE_W-1:0]  out_phase;

  // Rise ramp datapath.
  logic [TICK_W-1:0]          rise_t;
  logic [INC_W+TICK_W-1:0]    rise_prod;
  logic [INC_W+TICK_W:0]      rise_sum;
  logic [LEVEL_W-1:0]         rise_level;
  logic [TICK_W-1:0]          tick_inc;
  logic                       tick_fire;

  // Config writes are always taken; the user must send them only while the block is idle (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level     <= '0;
      start_level    <= '0;
      peak_level     <= '0;
      step_level     <= '0;
      rise_increment <= '0;
      rise_ticks     <= RISE_TICKS_RST;
      peak_ticks     <= PEAK_TICKS_RST;
      base_ticks     <= BASE_TICKS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_BASE_LEVEL:     base_level     <= cfg.data[LEVEL_W-1:0];
        REG_START_LEVEL:    start_level    <= cfg.data[LEVEL_W-1:0];
        REG_PEAK_LEVEL:     peak_level     <= cfg.data[LEVEL_W-1:0];
        REG_STEP_LEVEL:     step_level     <= cfg.data[LEVEL_W-1:0];
        REG_RISE_INCREMENT: rise_increment <= cfg.data[INC_W-1:0];
        REG_RISE_TICKS:     rise_ticks     <= cfg.data[TICK_W-1:0];
        REG_PEAK_TICKS:     peak_ticks     <= cfg.data[TICK_W-1:0];
        REG_BASE_TICKS:     base_ticks     <= cfg.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new tick whenever the output slot is empty or being drained.
  assign tick.ready = !out_valid || dac.ready;
  assign tick_fire  = tick.valid && tick.ready;

  // An unknown phase code behaves as the rise phase with the counter at zero.
  assign rise_t    = (phase_q == PH_RISE) ? tick_count : '0;
  assign rise_prod = rise_increment * rise_t;
  assign rise_sum  = (INC_W+TICK_W+1)'(base_level) + (INC_W+TICK_W+1)'(rise_prod);
  assign rise_level = (rise_sum > (INC_W+TICK_W+1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                                 : rise_sum[LEVEL_W-1:0];
  assign tick_inc  = tick_count + TICK_W'(1);

  always_comb begin
    phase_next      = phase_q;
    tick_count_next = tick_count;
    level_next      = base_level;
    unique case (phase_q)
      PH_START: begin
        // Start pulse lasts at most one tick; go to peak either way.
        phase_next = PH_PEAK;
        if (tick_count < START_LIM) begin
          level_next      = start_level;
          tick_count_next = tick_inc;
        end else begin
          level_next      = peak_level;
          tick_count_next = '0;
        end
      end
      PH_PEAK: begin
        if (tick_count < peak_ticks) begin
          level_next      = peak_level;
          tick_count_next = tick_inc;
        end else begin
          level_next      = step_level;
          tick_count_next = '0;
          phase_next      = PH_STEP;
        end
      end
      PH_STEP: begin
        if (tick_count < STEP_LIM) begin
          level_next      = step_level;
          tick_count_next = tick_inc;
        end else begin
          level_next      = base_level;
          tick_count_next = '0;
          phase_next      = PH_BASE;
        end
      end
      PH_BASE: begin
        level_next = base_level;
        if (tick_count < base_ticks) begin
          tick_count_next = tick_inc;
        end else begin
          tick_count_next = '0;
          phase_next      = PH_RISE;
        end
      end
      default: begin
        // Rise ramp, also the recovery path for a corrupt phase.
        if (rise_t <= rise_ticks) begin
          level_next      = rise_level;
          tick_count_next = rise_t + TICK_W'(1);
          phase_next      = PH_RISE;
        end else begin
          level_next      = start_level;
          tick_count_next = '0;
          phase_next      = PH_START;
        end
      end
    endcase
  end

  // Advance the waveform only on enabled ticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q    <= PH_RISE;
      tick_count <= '0;
    end else if (tick_fire && tick.enable) begin
      phase_q    <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  // Load a word when the tick is enabled and the DAC link can take it;
  // drop the slot once the sink takes the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= tick.enable && tick.dac_ready;
    end else if (dac.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_word  <= DAC_CMD + WORD_W'(level_next);
      out_phase <= phase_code(phase_next);
    end
  end

  assign dac.valid    = out_valid;
  assign dac.dac_word = out_word;
  assign dac.phase    = out_phase;

  // A disabled tick must leave the waveform untouched.
  `PCWS_ASSERT_NXT(a_disabled_holds, clk, rst, tick_fire && !tick.enable,
                   $stable(phase_q) && $stable(tick_count))
  // An enabled tick with the link ready always yields a word.
  `PCWS_ASSERT_NXT(a_word_follows, clk, rst, tick_fire && tick.enable && tick.dac_ready,
                   out_valid)
  // Entering the rise phase from base always restarts the counter.
  `PCWS_ASSERT_IMP(a_rise_restart, clk, rst,
                   phase_q == PH_RISE && $past(phase_q) == PH_BASE,
                   tick_count == '0)

endmodule
